// ===== sv/oaht_pkg.sv =====
// Package for the open-addressing hash table.
// Field widths, reset values of the control registers and the operation,
// status, slot, probe mode and register index codes. No dependencies.
package oaht_pkg;

   localparam int unsigned CAPACITY_DEF    = 1024;
   localparam int unsigned VALUE_WIDTH_DEF = 32;
   localparam int unsigned KEY_WIDTH_DEF   = 32;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned HASH_W  = 32;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned CFG_W   = 11;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned IDX_W   = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned SLOT_W  = 10;
   localparam int unsigned COUNT_W = 11;

   localparam logic [CFG_W-1:0] INIT_TABLE_SIZE = 11'd11;
   localparam logic [CFG_W-1:0] INIT_SECOND_MOD = 11'd7;

   typedef enum logic [OP_W-1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_SUCCESS   = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_FULL    = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR    = 2'd0,
      MODE_QUADRATIC = 2'd1,
      MODE_DOUBLE    = 2'd2
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      REG_PROBE_MODE  = 2'd0,
      REG_TABLE_SIZE  = 2'd1,
      REG_SECOND_MOD  = 2'd2
   } reg_type;

endpackage

// ===== sv/open_addressing_hash_table.sv =====
// Open-addressing hash table with tombstones, top level.
// Holds the slot store, a shared bit-serial remainder unit and the probe
// sequencer. Depends on oaht_pkg.
//
//   channel | signals                                   | direction
//   req     | req_valid req_stall req_op/key/value      | in, stall out
//   rsp     | rsp_valid rsp_stall rsp_status ... count  | out, stall in
//   csr     | csr_valid csr_ready csr_index csr_data    | in, ready out
//
// After reset a clearing pass empties every slot of the slot store; no
// transaction is taken meanwhile. Each put, get or remove then runs one
// remainder for the home slot, two more for double hashing, and a read
// state and a check state per probed slot; the remainder unit and the
// single memory port set this. A stalled response holds the block until
// it is taken.
module open_addressing_hash_table
   #(parameter int unsigned CAPACITY    = oaht_pkg::CAPACITY_DEF,
     parameter int unsigned VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF,
     parameter int unsigned KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF)
   (input  logic                              clock,
    input  logic                              reset,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [oaht_pkg::OP_W-1:0]         req_op,
    input  logic signed [oaht_pkg::HASH_W-1:0] req_key_hash,
    input  logic [oaht_pkg::DATA_W-1:0]       req_value_in,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [oaht_pkg::STAT_W-1:0]       rsp_status,
    output logic                              rsp_found,
    output logic [oaht_pkg::DATA_W-1:0]       rsp_value_out,
    output logic [oaht_pkg::SLOT_W-1:0]       rsp_slot_index,
    output logic [oaht_pkg::COUNT_W-1:0]      rsp_entry_count,
    input  logic                              csr_valid,
    output logic                              csr_ready,
    input  logic [oaht_pkg::IDX_W-1:0]        csr_index,
    input  logic [oaht_pkg::CFG_W-1:0]        csr_data);

   import oaht_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = ADDR_W + 1;
   localparam int unsigned BIT_W  = $clog2(HASH_W);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_PROBE_RD, S_PROBE_CHK, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      J_HOME_SIZE, J_HOME_MOD, J_STEP_SIZE
   } job_type;

   state_type                state_ff, state_in;
   job_type                  job_ff, job_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [HASH_W-1:0]        home_ff, home_in;
   logic [CFG_W-1:0]         size_ff, size_in;
   logic [CFG_W-1:0]         mod_ff, mod_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [HASH_W-1:0]        dvd_ff, dvd_in;
   logic [CFG_W-1:0]         div_ff, div_in;
   logic [CFG_W-1:0]         rem_ff, rem_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [CFG_W-1:0]         pos_ff, pos_in;
   logic [CFG_W-1:0]         inc_ff, inc_in;
   logic [CFG_W-1:0]         cnt_i_ff, cnt_i_in;
   logic [CNT_W-1:0]         clr_ff, clr_in;
   logic [CNT_W-1:0]         full_ff, full_in;
   logic [MODE_W-1:0]        cfg_mode_ff, cfg_mode_in;
   logic [CFG_W-1:0]         cfg_size_ff, cfg_size_in;
   logic [CFG_W-1:0]         cfg_mod_ff, cfg_mod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic                     found_ff, found_in;
   logic [DATA_W-1:0]        vout_ff, vout_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;

   logic [1:0]               mem_state [CAPACITY];
   logic [KEY_WIDTH-1:0]     mem_key [CAPACITY];
   logic [VALUE_WIDTH-1:0]   mem_value [CAPACITY];
   logic [1:0]               rd_state_ff;
   logic [KEY_WIDTH-1:0]     rd_key_ff;
   logic [VALUE_WIDTH-1:0]   rd_value_ff;

   logic                     we_state, we_kv;
   logic [ADDR_W-1:0]        wr_addr;
   logic [1:0]               wr_state;

   logic [CFG_W-1:0]         size_use, mod_use;
   logic [CFG_W:0]           trial, pos_sum, inc_sum;
   logic                     trial_ge;
   logic [CFG_W-1:0]         rem_next, pos_next, inc_next, init_inc;
   logic [HASH_W-1:0]        home_abs;
   logic                     hit, last;

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_value_out   = vout_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_entry_count = COUNT_W'(full_ff);

   always_comb begin
      if (cfg_size_ff == '0) begin
         size_use = CFG_W'(1);
      end else if (32'(cfg_size_ff) > 32'(CAPACITY)) begin
         size_use = CFG_W'(CAPACITY);
      end else begin
         size_use = cfg_size_ff;
      end
      mod_use  = (cfg_mod_ff == '0) ? CFG_W'(1) : cfg_mod_ff;
      home_abs = req_key_hash[HASH_W-1] ? (HASH_W'(0) - HASH_W'(req_key_hash))
                                        : HASH_W'(req_key_hash);

      trial    = {rem_ff, dvd_ff[HASH_W-1]};
      trial_ge = (trial >= {1'b0, div_ff});
      rem_next = trial_ge ? CFG_W'(trial - {1'b0, div_ff}) : trial[CFG_W-1:0];

      pos_sum  = {1'b0, pos_ff} + {1'b0, inc_ff};
      pos_next = (pos_sum >= {1'b0, size_ff}) ? CFG_W'(pos_sum - {1'b0, size_ff})
                                              : pos_sum[CFG_W-1:0];
      inc_sum  = {1'b0, inc_ff} + (CFG_W+1)'(2);
      if (size_ff == CFG_W'(1)) begin
         inc_next = '0;
      end else if (inc_sum >= {1'b0, size_ff}) begin
         inc_next = CFG_W'(inc_sum - {1'b0, size_ff});
      end else begin
         inc_next = inc_sum[CFG_W-1:0];
      end
      init_inc = (size_ff == CFG_W'(1)) ? '0 : CFG_W'(1);

      hit  = (rd_state_ff == SLOT_FULL) && (rd_key_ff == key_ff);
      last = ((cnt_i_ff + CFG_W'(1)) == size_ff);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      home_in      = home_ff;
      size_in      = size_ff;
      mod_in       = mod_ff;
      mode_in      = mode_ff;
      dvd_in       = dvd_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      pos_in       = pos_ff;
      inc_in       = inc_ff;
      cnt_i_in     = cnt_i_ff;
      clr_in       = clr_ff;
      full_in      = full_ff;
      cfg_mode_in  = cfg_mode_ff;
      cfg_size_in  = cfg_size_ff;
      cfg_mod_in   = cfg_mod_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      slot_in      = slot_ff;
      we_state     = 1'b0;
      we_kv        = 1'b0;
      wr_addr      = ADDR_W'(pos_ff);
      wr_state     = SLOT_FULL;

      if (csr_valid) begin
         case (csr_index)
            REG_PROBE_MODE: cfg_mode_in = csr_data[MODE_W-1:0];
            REG_TABLE_SIZE: cfg_size_in = csr_data;
            REG_SECOND_MOD: cfg_mod_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            we_state = 1'b1;
            wr_addr  = clr_ff[ADDR_W-1:0];
            wr_state = SLOT_EMPTY;
            clr_in   = clr_ff + CNT_W'(1);
            if (clr_ff == CNT_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = KEY_WIDTH'(HASH_W'(req_key_hash));
               val_in   = VALUE_WIDTH'(req_value_in);
               home_in  = home_abs;
               size_in  = size_use;
               mod_in   = mod_use;
               mode_in  = cfg_mode_ff;
               cnt_i_in = '0;
               if (req_op == OP_PUT || req_op == OP_GET || req_op == OP_REMOVE) begin
                  job_in   = J_HOME_SIZE;
                  dvd_in   = home_abs;
                  div_in   = size_use;
                  rem_in   = '0;
                  bit_in   = '0;
                  state_in = S_DIV;
               end else begin
                  status_in    = ST_NOT_FOUND;
                  found_in     = 1'b0;
                  vout_in      = '0;
                  slot_in      = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end
         S_DIV: begin
            rem_in = rem_next;
            dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(HASH_W - 1)) begin
               bit_in = '0;
               rem_in = '0;
               case (job_ff)
                  J_HOME_SIZE: begin
                     pos_in = rem_next;
                     if (mode_ff == MODE_DOUBLE) begin
                        job_in = J_HOME_MOD;
                        dvd_in = home_ff;
                        div_in = mod_ff;
                     end else begin
                        inc_in   = init_inc;
                        state_in = S_PROBE_RD;
                     end
                  end
                  J_HOME_MOD: begin
                     job_in = J_STEP_SIZE;
                     dvd_in = HASH_W'(mod_ff - rem_next);
                     div_in = size_ff;
                  end
                  default: begin
                     inc_in   = rem_next;
                     state_in = S_PROBE_RD;
                  end
               endcase
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            found_in = 1'b0;
            vout_in  = '0;
            slot_in  = '0;
            if (op_ff == OP_PUT) begin
               if (rd_state_ff != SLOT_FULL || rd_key_ff == key_ff) begin
                  we_state  = 1'b1;
                  we_kv     = 1'b1;
                  if (rd_state_ff != SLOT_FULL) begin
                     full_in = full_ff + CNT_W'(1);
                  end
                  status_in    = ST_SUCCESS;
                  slot_in      = SLOT_W'(pos_ff);
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else if (last) begin
                  status_in    = ST_FULL;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
            end else begin
               if (rd_state_ff == SLOT_EMPTY) begin
                  status_in    = ST_NOT_FOUND;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else if (hit) begin
                  status_in = ST_SUCCESS;
                  found_in  = 1'b1;
                  slot_in   = SLOT_W'(pos_ff);
                  if (op_ff == OP_GET) begin
                     vout_in = DATA_W'(rd_value_ff);
                  end else begin
                     we_state = 1'b1;
                     wr_state = SLOT_DELETED;
                     if (full_ff != '0) begin
                        full_in = full_ff - CNT_W'(1);
                     end
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else if (last) begin
                  status_in    = ST_NOT_FOUND;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
            end
            if (state_in == S_PROBE_CHK) begin
               cnt_i_in = cnt_i_ff + CFG_W'(1);
               pos_in   = pos_next;
               if (mode_ff == MODE_QUADRATIC) begin
                  inc_in = inc_next;
               end
               state_in = S_PROBE_RD;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         job_ff       <= J_HOME_SIZE;
         bit_ff       <= '0;
         clr_ff       <= '0;
         full_ff      <= '0;
         cfg_mode_ff  <= MODE_LINEAR;
         cfg_size_ff  <= INIT_TABLE_SIZE;
         cfg_mod_ff   <= INIT_SECOND_MOD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         bit_ff       <= bit_in;
         clr_ff       <= clr_in;
         full_ff      <= full_in;
         cfg_mode_ff  <= cfg_mode_in;
         cfg_size_ff  <= cfg_size_in;
         cfg_mod_ff   <= cfg_mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      home_ff   <= home_in;
      size_ff   <= size_in;
      mod_ff    <= mod_in;
      mode_ff   <= mode_in;
      dvd_ff    <= dvd_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      pos_ff    <= pos_in;
      inc_ff    <= inc_in;
      cnt_i_ff  <= cnt_i_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      vout_ff   <= vout_in;
      slot_ff   <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (we_state) begin
         mem_state[wr_addr] <= wr_state;
      end
      if (we_kv) begin
         mem_key[wr_addr]   <= key_ff;
         mem_value[wr_addr] <= val_ff;
      end
      rd_state_ff <= mem_state[ADDR_W'(pos_ff)];
      rd_key_ff   <= mem_key[ADDR_W'(pos_ff)];
      rd_value_ff <= mem_value[ADDR_W'(pos_ff)];
   end

endmodule

// ===== tb/testbench.sv =====
// Testbench for open_addressing_hash_table: random and directed put/get/remove
// traffic under several probe settings, checked against a scoreboard model.
// Depends on oaht_pkg and the open_addressing_hash_table RTL.
module testbench;
   import oaht_pkg::*;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic               found;
      logic [DATA_W-1:0]  value;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } answer_type;

   class table_scoreboard;
      slot_type          slot_st[CAPACITY_DEF];
      logic [HASH_W-1:0] slot_key[CAPACITY_DEF];
      logic [DATA_W-1:0] slot_val[CAPACITY_DEF];
      int unsigned       full_count;
      logic [MODE_W-1:0] mode;
      logic [CFG_W-1:0]  size_reg;
      logic [CFG_W-1:0]  step_mod;
      answer_type        answers[$];
      int unsigned       errors;
      int unsigned       checked;

      function new();
         foreach (slot_st[i]) slot_st[i] = SLOT_EMPTY;
         full_count = 0;
         mode = MODE_LINEAR;
         size_reg = INIT_TABLE_SIZE;
         step_mod = INIT_SECOND_MOD;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(reg_type idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_PROBE_MODE: mode = data[MODE_W-1:0];
            REG_TABLE_SIZE: size_reg = data;
            REG_SECOND_MOD: step_mod = data;
            default: ;
         endcase
      endfunction

      function int unsigned probe_slot(longint unsigned home, longint unsigned i,
                                       longint unsigned size);
         longint unsigned m;
         longint unsigned p;
         m = (step_mod == 0) ? 1 : step_mod;
         if (mode == MODE_QUADRATIC) p = home + i * i;
         else if (mode == MODE_DOUBLE) p = home + i * (m - home % m);
         else p = home + i;
         return 32'(p % size);
      endfunction

      function void note(logic [OP_W-1:0] op, logic [HASH_W-1:0] key,
                         logic [DATA_W-1:0] val);
         answer_type a;
         longint unsigned home;
         int unsigned size;
         int unsigned p;
         home = key[HASH_W-1] ? (64'h1_0000_0000 - {32'b0, key}) : {32'b0, key};
         size = (size_reg == 0) ? 1 : (size_reg > CAPACITY_DEF) ? CAPACITY_DEF : size_reg;
         a.status = ST_NOT_FOUND;
         a.found = 0;
         a.value = '0;
         a.slot = '0;
         if (op == OP_PUT) begin
            a.status = ST_FULL;
            for (int i = 0; i < size; i++) begin
               p = probe_slot(home, i, size);
               if (slot_st[p] != SLOT_FULL || slot_key[p] == key) begin
                  if (slot_st[p] != SLOT_FULL) full_count++;
                  slot_st[p] = SLOT_FULL;
                  slot_key[p] = key;
                  slot_val[p] = val;
                  a.status = ST_SUCCESS;
                  a.slot = SLOT_W'(p);
                  break;
               end
            end
         end else if (op == OP_GET || op == OP_REMOVE) begin
            for (int i = 0; i < size; i++) begin
               p = probe_slot(home, i, size);
               if (slot_st[p] == SLOT_EMPTY) break;
               if (slot_st[p] == SLOT_FULL && slot_key[p] == key) begin
                  a.status = ST_SUCCESS;
                  a.found = 1;
                  a.slot = SLOT_W'(p);
                  if (op == OP_GET) begin
                     a.value = slot_val[p];
                  end else begin
                     slot_st[p] = SLOT_DELETED;
                     if (full_count > 0) full_count--;
                  end
                  break;
               end
            end
         end
         a.count = COUNT_W'(full_count);
         answers.push_back(a);
      endfunction

      function void check(answer_type got);
         answer_type e;
         if (answers.size() == 0) begin
            $display("%0t: unexpected response status=%0d slot=%0d", $time, got.status,
                     got.slot);
            errors++;
            return;
         end
         e = answers.pop_front();
         checked++;
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.found !== e.found) begin
            $display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
            errors++;
         end
         if (got.value !== e.value) begin
            $display("%0t: value_out expected %h actual %h", $time, e.value, got.value);
            errors++;
         end
         if (got.slot !== e.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, e.slot, got.slot);
            errors++;
         end
         if (got.count !== e.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, e.count, got.count);
            errors++;
         end
      endfunction
   endclass

   localparam longint LIMIT = 10000000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op = OP_PUT;
   logic signed [HASH_W-1:0] req_key_hash = '0;
   logic [DATA_W-1:0]        req_value_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_found;
   logic [DATA_W-1:0]        rsp_value_out;
   logic [SLOT_W-1:0]        rsp_slot_index;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic                     csr_valid = 0;
   logic                     csr_ready;
   logic [IDX_W-1:0]         csr_index = REG_PROBE_MODE;
   logic [CFG_W-1:0]         csr_data = '0;

   table_scoreboard sb = new();
   longint   cycles = 0;
   int       stall_left = 0;
   int       items = 0;
   logic [HASH_W-1:0] keys[16];

   open_addressing_hash_table u_dut (.*);

   initial forever #2 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles,
                  sb.answers.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         n = gap_len();
         rsp_stall <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
      end
   end

   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.found = rsp_found;
         got.value = rsp_value_out;
         got.slot = rsp_slot_index;
         got.count = rsp_entry_count;
         sb.check(got);
      end
   end

   task automatic send(logic [OP_W-1:0] op, logic [HASH_W-1:0] key,
                       logic [DATA_W-1:0] val);
      int n;
      req_valid <= 1;
      req_op <= op;
      req_key_hash <= key;
      req_value_in <= val;
      do @(posedge clock); while (req_stall);
      sb.note(op, key, val);
      items++;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [CFG_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic setup(logic [MODE_W-1:0] m, logic [CFG_W-1:0] size,
                        logic [CFG_W-1:0] step);
      drain();
      write_reg(REG_PROBE_MODE, CFG_W'(m));
      write_reg(REG_TABLE_SIZE, size);
      write_reg(REG_SECOND_MOD, step);
   endtask

   task automatic random_phase(int count);
      logic [OP_W-1:0] op;
      logic [HASH_W-1:0] key;
      int r;
      foreach (keys[i]) begin
         keys[i] = $urandom_range(0, 3000);
         if ($urandom_range(0, 1)) keys[i] = -keys[i];
      end
      keys[0] = 32'h8000_0000;
      repeat (count) begin
         r = $urandom_range(0, 99);
         op = (r < 42) ? OP_PUT : (r < 72) ? OP_GET : (r < 95) ? OP_REMOVE : 2'd3;
         key = ($urandom_range(0, 9) == 0) ? $urandom : keys[$urandom_range(0, 15)];
         send(op, key, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(OP_GET, 32'd5, '0);
      send(OP_REMOVE, 32'd5, '0);
      send(OP_PUT, 32'd0, 32'h0000_0000);
      send(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send(OP_PUT, 32'h8000_0000, 32'hA5A5_5A5A);
      send(OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      send(OP_PUT, 32'd1, 32'h1234_5678);
      send(OP_GET, 32'h8000_0000, '0);
      send(OP_GET, 32'hFFFF_FFFF, '0);
      send(OP_GET, 32'd1, '0);
      send(OP_PUT, 32'd1, 32'hDEAD_BEEF);
      send(OP_GET, 32'd1, '0);
      send(OP_REMOVE, 32'hFFFF_FFFF, '0);
      send(OP_GET, 32'd1, '0);
      send(OP_GET, 32'hFFFF_FFFF, '0);
      send(2'd3, 32'd0, 32'hFFFF_FFFF);
      send(OP_PUT, 32'd12, 32'h0BAD_CAFE);
      send(OP_GET, 32'd12, '0);
      random_phase(60);
      setup(MODE_LINEAR, 11'd2, 11'd1);
      send(OP_PUT, 32'd4, 32'd1);
      send(OP_PUT, -32'sd7, 32'd2);
      send(OP_PUT, 32'd9, 32'd3);
      send(OP_PUT, 32'd4, 32'd4);
      random_phase(40);
      setup(MODE_QUADRATIC, 11'd16, 11'd13);
      random_phase(80);
      setup(MODE_DOUBLE, 11'd13, 11'd11);
      random_phase(80);
      setup(MODE_DOUBLE, 11'd64, 11'd0);
      random_phase(70);
      setup(2'd3, 11'd8, 11'd5);
      random_phase(60);
      setup(MODE_LINEAR, 11'd1024, 11'd1024);
      random_phase(40);
      setup(MODE_QUADRATIC, 11'd0, 11'd3);
      random_phase(30);
      setup(MODE_DOUBLE, 11'd2047, 11'd2047);
      random_phase(40);
      setup(MODE_LINEAR, 11'd31, 11'd29);
      random_phase(128);
      drain();
      repeat (100) @(posedge clock);
      $display("sent %0d operations over ten probe settings, %0d responses compared",
               items, sb.checked);
      $display("settings covered linear, quadratic, double hashing and odd sizes");
      if (sb.errors == 0 && sb.answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
